// ===== rtl/pp_pkg.sv =====
// Package for the pure pursuit steering block: widths, codes, CORDIC constants.
package pp_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int CFG_W      = 24;
    localparam int COORD_W    = 32;
    localparam int HEAD_W     = 16;
    localparam int STEER_W    = 15;
    localparam int TIDX_W     = 12;
    localparam int ANG_W      = 36;
    localparam int XY_W       = 60;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 64;
    localparam int ITER_W     = 5;
    localparam int CORDIC_STEPS = 30;

    localparam logic [ANG_W-1:0] ANG_PI      = 36'd3373259426;
    localparam logic [ANG_W-1:0] ANG_HALF_PI = 36'd1686629713;
    localparam logic [ANG_W-1:0] ANG_TWO_PI  = 36'd6746518852;
    localparam logic [XY_W-1:0]  INV_GAIN    = 60'd652032874;
    localparam int               STEER_LIMIT = 12868;

    localparam logic CFG_WHEELBASE = 1'b0;
    localparam logic CFG_LOOKAHEAD = 1'b1;

    localparam logic OP_POSE  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_L2, S_CMP, S_END,
        S_RPRE, S_VPRE, S_ITER, S_NUM, S_MULW, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_HEAD, PH_ALPHA, PH_SIN, PH_STEER
    } t_phase;

    // atan(2^-i) scaled by 2^30, truncated
    function automatic logic [ANG_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [ANG_W-1:0] v;
        begin
            unique case (i)
                5'd0:  v = 36'd843314856;
                5'd1:  v = 36'd497837829;
                5'd2:  v = 36'd263043836;
                5'd3:  v = 36'd133525158;
                5'd4:  v = 36'd67021686;
                5'd5:  v = 36'd33543515;
                5'd6:  v = 36'd16775850;
                5'd7:  v = 36'd8388437;
                5'd8:  v = 36'd4194282;
                5'd9:  v = 36'd2097149;
                5'd10: v = 36'd1048575;
                5'd11: v = 36'd524287;
                5'd12: v = 36'd262143;
                5'd13: v = 36'd131071;
                5'd14: v = 36'd65535;
                5'd15: v = 36'd32767;
                5'd16: v = 36'd16383;
                5'd17: v = 36'd8191;
                5'd18: v = 36'd4095;
                5'd19: v = 36'd2047;
                5'd20: v = 36'd1023;
                5'd21: v = 36'd511;
                5'd22: v = 36'd255;
                5'd23: v = 36'd127;
                5'd24: v = 36'd63;
                5'd25: v = 36'd31;
                5'd26: v = 36'd15;
                5'd27: v = 36'd7;
                5'd28: v = 36'd3;
                5'd29: v = 36'd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/pure_pursuit_steering_top.sv =====
// Pure pursuit steering: lookahead point search and CORDIC steer angle.
// Pose item: accepted in idle; when marked last it goes straight to the result. Path point:
// dx^2, dy^2, lookahead^2 through the shared 33x33 multiplier, then the compare.
// Last point: after the compare, four 30-step passes of one CORDIC stage with pre-fold
// and one multiply in between lead to the result and the next request.
// Synchronous active-low reset clears pose, run state and the output valid flag.
module pure_pursuit_steering_top #(
    parameter int MAX_POINTS = pp_pkg::MAX_POINTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [79:0]                i_s_tdata,   // coord_x, coord_y, heading
    input  logic [0:0]                 i_s_tuser,   // operation
    input  logic                       i_s_tlast,   // last
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [31:0]                o_m_tdata,   // steer_angle, target_index, zero pad
    output logic [1:0]                 o_m_tuser,   // lookahead_met, empty_path
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [pp_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int AW = pp_pkg::ANG_W;
    localparam int XW = pp_pkg::XY_W;
    localparam int CW = pp_pkg::COORD_W;

    pp_pkg::t_state r_state, n_state;
    pp_pkg::t_phase r_phase, n_phase;

    logic [pp_pkg::CFG_W-1:0]  r_wb, r_la;
    logic signed [CW-1:0]      r_px, r_py, n_px, n_py;
    logic signed [pp_pkg::HEAD_W-1:0] r_ph, n_ph;
    logic signed [CW-1:0]      r_dx, r_dy, n_dx, n_dy;
    logic signed [CW-1:0]      r_bdx, r_bdy, r_fdx, r_fdy, n_bdx, n_bdy, n_fdx, n_fdy;
    logic [63:0]               r_best, n_best, r_acc, n_acc, r_prod, n_prod;
    logic [pp_pkg::TIDX_W-1:0] r_bidx, n_bidx, r_ridx, n_ridx;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_found, n_found, r_last, n_last;
    logic                      r_rmet, n_rmet, r_rempty, n_rempty;
    logic signed [XW-1:0]      r_x, r_y, n_x, n_y;
    logic signed [AW-1:0]      r_z, n_z;
    logic [pp_pkg::ITER_W-1:0] r_it, n_it;
    logic                      r_ov, n_ov;
    logic [pp_pkg::STEER_W-1:0] r_steer, n_steer;
    logic [pp_pkg::TIDX_W-1:0] r_oidx, n_oidx;
    logic                      r_omet, n_omet, r_oempty, n_oempty;

    // shared multiplier operands
    logic signed [pp_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [2*pp_pkg::MUL_W-1:0] mul_p;

    // CORDIC stage and helpers
    logic signed [XW-1:0] xs, ys;
    logic signed [AW-1:0] atan_v, zw, zr;
    logic                 sigma, fold_neg;
    logic signed [CW:0]   dxw, dyw;
    logic signed [CW-1:0] dx_sat, dy_sat;
    logic signed [AW-1:0] q_full;
    logic                 in_acc;

    function automatic logic signed [CW-1:0] sat33(input logic signed [CW:0] d);
        if (d[CW] != d[CW-1]) begin
            return d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return d[CW-1:0];
    endfunction

    assign in_acc = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == pp_pkg::S_IDLE);

    assign dxw = {i_s_tdata[31], i_s_tdata[31:0]} - {r_px[CW-1], r_px};
    assign dyw = {i_s_tdata[63], i_s_tdata[63:32]} - {r_py[CW-1], r_py};
    assign dx_sat = sat33(dxw);
    assign dy_sat = sat33(dyw);

    assign xs = r_x >>> r_it;
    assign ys = r_y >>> r_it;
    assign atan_v = signed'(pp_pkg::atan_lut(r_it));
    assign sigma = (r_phase == pp_pkg::PH_HEAD || r_phase == pp_pkg::PH_SIN)
                   ? (r_z >= 0) : (r_y < 0);

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            pp_pkg::S_SQX: begin
                mul_a = {r_dx[CW-1], r_dx};
                mul_b = {r_dx[CW-1], r_dx};
            end
            pp_pkg::S_SQY: begin
                mul_a = {r_dy[CW-1], r_dy};
                mul_b = {r_dy[CW-1], r_dy};
            end
            pp_pkg::S_L2: begin
                mul_a = signed'({{(pp_pkg::MUL_W-pp_pkg::CFG_W){1'b0}}, r_la});
                mul_b = signed'({{(pp_pkg::MUL_W-pp_pkg::CFG_W){1'b0}}, r_la});
            end
            pp_pkg::S_NUM: begin
                mul_a = r_y[pp_pkg::MUL_W-1:0];
                mul_b = signed'({{(pp_pkg::MUL_W-pp_pkg::CFG_W){1'b0}}, r_wb});
            end
            default: ;
        endcase
    end

    // rotation pre-fold: wrap into [-pi, pi], then into [-pi/2, pi/2]
    always_comb begin
        zw = r_z;
        if (zw > signed'(pp_pkg::ANG_PI)) begin
            zw = zw - signed'(pp_pkg::ANG_TWO_PI);
        end
        if (zw < -signed'(pp_pkg::ANG_PI)) begin
            zw = zw + signed'(pp_pkg::ANG_TWO_PI);
        end
        fold_neg = 1'b0;
        zr = zw;
        if (zw > signed'(pp_pkg::ANG_HALF_PI)) begin
            fold_neg = 1'b1;
            zr = zw - signed'(pp_pkg::ANG_PI);
        end else if (zw < -signed'(pp_pkg::ANG_HALF_PI)) begin
            fold_neg = 1'b1;
            zr = zw + signed'(pp_pkg::ANG_PI);
        end
    end

    assign q_full = (r_z + AW'(65536)) >>> 17;

    always_comb begin
        n_state = r_state;   n_phase = r_phase;
        n_px = r_px;  n_py = r_py;  n_ph = r_ph;
        n_dx = r_dx;  n_dy = r_dy;
        n_bdx = r_bdx; n_bdy = r_bdy; n_fdx = r_fdx; n_fdy = r_fdy;
        n_best = r_best; n_acc = r_acc; n_prod = r_prod;
        n_bidx = r_bidx; n_ridx = r_ridx; n_cnt = r_cnt;
        n_found = r_found; n_last = r_last; n_rmet = r_rmet; n_rempty = r_rempty;
        n_x = r_x; n_y = r_y; n_z = r_z; n_it = r_it;
        n_ov = r_ov; n_steer = r_steer; n_oidx = r_oidx;
        n_omet = r_omet; n_oempty = r_oempty;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            pp_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_last = i_s_tlast;
                    if (i_s_tuser[0] == pp_pkg::OP_POSE) begin
                        n_px = i_s_tdata[31:0];
                        n_py = i_s_tdata[63:32];
                        n_ph = i_s_tdata[79:64];
                        n_best = '1; n_bdx = '0; n_bdy = '0; n_fdx = '0; n_fdy = '0;
                        n_bidx = '0; n_cnt = '0; n_found = 1'b0;
                        if (i_s_tlast) begin
                            n_z = '0;
                            n_ridx = '0; n_rmet = 1'b0; n_rempty = 1'b1;
                            n_state = pp_pkg::S_OUT;
                        end
                    end else begin
                        n_dx = dx_sat;
                        n_dy = dy_sat;
                        n_state = pp_pkg::S_SQX;
                    end
                end
            end
            pp_pkg::S_SQX: begin
                n_prod = mul_p[63:0];
                n_state = pp_pkg::S_SQY;
            end
            pp_pkg::S_SQY: begin
                n_acc = r_prod;
                n_prod = mul_p[63:0];
                n_state = pp_pkg::S_L2;
            end
            pp_pkg::S_L2: begin
                n_acc = r_acc + r_prod;
                n_prod = mul_p[63:0];
                n_state = pp_pkg::S_CMP;
            end
            pp_pkg::S_CMP: begin
                if (r_cnt < CNT_W'(MAX_POINTS)) begin
                    if (r_cnt == '0) begin
                        n_fdx = r_dx;
                        n_fdy = r_dy;
                    end
                    if (r_acc >= r_prod && r_acc < r_best) begin
                        n_best = r_acc;
                        n_bdx = r_dx;
                        n_bdy = r_dy;
                        n_bidx = pp_pkg::TIDX_W'(r_cnt);
                        n_found = 1'b1;
                    end
                    n_cnt = r_cnt + 1'b1;
                end
                n_state = r_last ? pp_pkg::S_END : pp_pkg::S_IDLE;
            end
            pp_pkg::S_END: begin
                n_x = r_found ? XW'(r_bdx) : XW'(r_fdx);
                n_y = r_found ? XW'(r_bdy) : XW'(r_fdy);
                n_z = -(AW'(r_ph) <<< 17);
                n_ridx = r_found ? r_bidx : '0;
                n_rmet = r_found;
                n_rempty = 1'b0;
                n_best = '1; n_bdx = '0; n_bdy = '0; n_fdx = '0; n_fdy = '0;
                n_bidx = '0; n_cnt = '0; n_found = 1'b0;
                n_phase = pp_pkg::PH_HEAD;
                n_state = pp_pkg::S_RPRE;
            end
            pp_pkg::S_RPRE: begin
                n_z = zr;
                if (fold_neg) begin
                    n_x = -r_x;
                    n_y = -r_y;
                end
                n_it = '0;
                n_state = pp_pkg::S_ITER;
            end
            pp_pkg::S_VPRE: begin
                n_it = '0;
                if (r_x == '0 && r_y == '0) begin
                    n_z = '0;
                    n_it = pp_pkg::ITER_W'(pp_pkg::CORDIC_STEPS - 1);
                    n_state = pp_pkg::S_ITER;
                    // zero vector: one dummy pass would move z; finish directly
                    if (r_phase == pp_pkg::PH_ALPHA) begin
                        n_x = pp_pkg::INV_GAIN;
                        n_y = '0;
                        n_phase = pp_pkg::PH_SIN;
                        n_state = pp_pkg::S_RPRE;
                    end else begin
                        n_state = pp_pkg::S_OUT;
                    end
                end else begin
                    n_z = '0;
                    if (r_x < 0) begin
                        n_z = (r_y >= 0) ? signed'(pp_pkg::ANG_PI) : -signed'(pp_pkg::ANG_PI);
                        n_x = -r_x;
                        n_y = -r_y;
                    end
                    n_state = pp_pkg::S_ITER;
                end
            end
            pp_pkg::S_ITER: begin
                if (sigma) begin
                    n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - atan_v;
                end else begin
                    n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + atan_v;
                end
                n_it = r_it + 1'b1;
                if (r_it == pp_pkg::ITER_W'(pp_pkg::CORDIC_STEPS - 1)) begin
                    unique case (r_phase)
                        pp_pkg::PH_HEAD: begin
                            n_phase = pp_pkg::PH_ALPHA;
                            n_state = pp_pkg::S_VPRE;
                        end
                        pp_pkg::PH_ALPHA: begin
                            n_x = pp_pkg::INV_GAIN;
                            n_y = '0;
                            n_phase = pp_pkg::PH_SIN;
                            n_state = pp_pkg::S_RPRE;
                        end
                        pp_pkg::PH_SIN: n_state = pp_pkg::S_NUM;
                        pp_pkg::PH_STEER: n_state = pp_pkg::S_OUT;
                        default: n_state = pp_pkg::S_IDLE;
                    endcase
                end
            end
            pp_pkg::S_NUM: begin
                n_prod = mul_p[63:0];
                n_state = pp_pkg::S_MULW;
            end
            pp_pkg::S_MULW: begin
                n_x = signed'({{(XW-pp_pkg::CFG_W-30){1'b0}}, r_la, 30'd0});
                n_y = {r_prod[XW-2:0], 1'b0};
                n_phase = pp_pkg::PH_STEER;
                n_state = pp_pkg::S_VPRE;
            end
            pp_pkg::S_OUT: begin
                if (!r_ov || i_m_tready) begin
                    n_ov = 1'b1;
                    if (r_rempty) begin
                        n_steer = '0;
                    end else if (q_full > AW'(pp_pkg::STEER_LIMIT)) begin
                        n_steer = pp_pkg::STEER_W'(pp_pkg::STEER_LIMIT);
                    end else if (q_full < -AW'(pp_pkg::STEER_LIMIT)) begin
                        n_steer = pp_pkg::STEER_W'(-pp_pkg::STEER_LIMIT);
                    end else begin
                        n_steer = q_full[pp_pkg::STEER_W-1:0];
                    end
                    n_oidx = r_ridx;
                    n_omet = r_rmet;
                    n_oempty = r_rempty;
                    n_state = pp_pkg::S_IDLE;
                end
            end
            default: n_state = pp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pp_pkg::S_IDLE;
            r_phase <= pp_pkg::PH_HEAD;
            r_wb <= pp_pkg::CFG_W'(65536);
            r_la <= pp_pkg::CFG_W'(65536);
            r_px <= '0; r_py <= '0; r_ph <= '0;
            r_best <= '1; r_bdx <= '0; r_bdy <= '0; r_fdx <= '0; r_fdy <= '0;
            r_bidx <= '0; r_cnt <= '0; r_found <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (i_cfg_we) begin
                if (i_cfg_idx[0] == pp_pkg::CFG_WHEELBASE) begin
                    r_wb <= i_cfg_data;
                end else begin
                    r_la <= i_cfg_data;
                end
            end
            r_px <= n_px; r_py <= n_py; r_ph <= n_ph;
            r_best <= n_best; r_bdx <= n_bdx; r_bdy <= n_bdy;
            r_fdx <= n_fdx; r_fdy <= n_fdy;
            r_bidx <= n_bidx; r_cnt <= n_cnt; r_found <= n_found;
            r_ov <= n_ov;
        end
        r_dx <= n_dx; r_dy <= n_dy;
        r_acc <= n_acc; r_prod <= n_prod;
        r_ridx <= n_ridx; r_rmet <= n_rmet; r_rempty <= n_rempty; r_last <= n_last;
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_it <= n_it;
        r_steer <= n_steer; r_oidx <= n_oidx; r_omet <= n_omet; r_oempty <= n_oempty;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'd0, r_oidx, r_steer};
    assign o_m_tuser  = {r_oempty, r_omet};

endmodule

// ===== rtl/pp_checker.sv =====
// Port-level checker for the pure pursuit steering block, bound to the top level.
module pp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    logic signed [pp_pkg::STEER_W-1:0] steer;
    assign steer = o_m_tdata[pp_pkg::STEER_W-1:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser[0] == pp_pkg::OP_POINT |=> !o_s_tready)
        else $error("ready after a point request");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata == 32'd0 && !o_m_tuser[0])
        else $error("empty path result not zero");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> steer <= 15'sd12868 && steer >= -15'sd12868)
        else $error("steer out of range");

endmodule

bind pure_pursuit_steering_top pp_checker u_pp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
